@@ design/blpc_pkg.sv @@
// Package: shared types and constants for the button and LED blink controller.
`timescale 1ns / 1ps

package blpc_pkg;

    localparam int CLK_W      = 32;
    localparam int DEBOUNCE_W = 10;
    localparam int LIMIT_W    = 16;
    localparam int LED_W      = 7;
    localparam int LED_IDX_W  = 3;
    localparam int RATE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [CLK_W-1:0]      ms_t;
    typedef logic [LIMIT_W-1:0]    limit_t;
    typedef logic [DEBOUNCE_W-1:0] debounce_t;
    typedef logic [LED_W-1:0]      leds_t;
    typedef logic [LED_IDX_W-1:0]  led_idx_t;
    typedef logic [RATE_W-1:0]     rate_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    // Result action codes
    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_SHORT  = 2'd1,
        ACT_MEDIUM = 2'd2,
        ACT_LONG   = 2'd3
    } action_t;

    // Configuration register indexes
    localparam cfg_idx_t CFG_DEBOUNCE = 3'd0;
    localparam cfg_idx_t CFG_SHORT    = 3'd1;
    localparam cfg_idx_t CFG_LONG     = 3'd2;
    localparam cfg_idx_t CFG_HP_SLOW  = 3'd3;
    localparam cfg_idx_t CFG_HP_MID   = 3'd4;
    localparam cfg_idx_t CFG_HP_FAST  = 3'd5;

    // Rate indexes
    localparam rate_t RATE_SLOW = 2'd0;
    localparam rate_t RATE_MID  = 2'd1;
    localparam rate_t RATE_FAST = 2'd2;

    // Register reset values
    localparam debounce_t DEBOUNCE_RST = 10'd50;
    localparam limit_t    SHORT_RST    = 16'd2000;
    localparam limit_t    LONG_RST     = 16'd4000;
    localparam limit_t    HP_SLOW_RST  = 16'd1667;
    localparam limit_t    HP_MID_RST   = 16'd333;
    localparam limit_t    HP_FAST_RST  = 16'd227;

    // Inputs to the release classifier
    typedef struct packed {
        ms_t    hold_ms;
        limit_t short_limit;
        limit_t long_limit;
        logic   blink_enabled;
    } press_info_t;

endpackage

@@ design/blpc_if.sv @@
// Interfaces: event input, status output and configuration write channels.
`timescale 1ns / 1ps

interface blpc_event_if;
    logic valid;
    logic ready;
    logic mode;
    logic pin_level;

    modport source (output valid, output mode, output pin_level, input ready);
    modport sink   (input valid, input mode, input pin_level, output ready);
    modport mon    (input valid, input mode, input pin_level, input ready);
endinterface

interface blpc_status_if;
    logic                valid;
    logic                ready;
    blpc_pkg::leds_t     lit_leds;
    logic                blink_on;
    blpc_pkg::rate_t     rate_select;
    blpc_pkg::action_t   action;

    modport source (output valid, output lit_leds, output blink_on, output rate_select,
                    output action, input ready);
    modport sink   (input valid, input lit_leds, input blink_on, input rate_select,
                    input action, output ready);
    modport mon    (input valid, input lit_leds, input blink_on, input rate_select,
                    input action, input ready);
endinterface

interface blpc_cfg_if;
    logic                  valid;
    logic                  ready;
    blpc_pkg::cfg_idx_t    index;
    blpc_pkg::cfg_data_t   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
    modport mon    (input valid, input index, input data, input ready);
endinterface

@@ design/blpc_press_class.sv @@
// Release classifier: sorts a hold time into short, medium or long action.
`timescale 1ns / 1ps

module blpc_press_class (
    input  blpc_pkg::press_info_t info,
    output blpc_pkg::action_t     action
);

    logic below_short;
    logic below_long;

    assign below_short = info.hold_ms < {16'd0, info.short_limit};
    assign below_long  = info.hold_ms < {16'd0, info.long_limit};

    // Short test wins even when the limits are out of order; a medium hold
    // with blinking off toggles blinking and reports as long.
    always_comb
    begin
        if (below_short)
        begin
            action = blpc_pkg::ACT_SHORT;
        end
        else if (below_long && info.blink_enabled)
        begin
            action = blpc_pkg::ACT_MEDIUM;
        end
        else
        begin
            action = blpc_pkg::ACT_LONG;
        end
    end

endmodule

@@ design/button_press_led_blink_controller_unit.sv @@
// Top level: debounced button press classifier driving a single blinking LED.
`timescale 1ns / 1ps
//
//  Channel   Role   Item / payload                                  Handshake
//  --------  -----  ----------------------------------------------  -----------
//  events    sink   mode (0 tick, 1 edge), pin_level                valid/ready
//  status    source lit_leds, blink_on, rate_select, action         valid/ready
//  cfg       sink   index (3b), data (16b) register write           valid/ready
//
//  Each item is held in the input register, then passes through the update
//  logic that writes the controller state and the result register; one
//  item per cycle sustained while the status channel is ready.
//  Throughput is set by the state update (clock, debounce,
//  hold classification and blink check all resolve in that one stage).
//  A stalled status channel holds the result register; the input register
//  still takes one more item, after which events.ready drops.
//  rst_n clears all control state and loads the register reset values;
//  cfg is always ready and takes effect on the next item.

module button_press_led_blink_controller_unit #(
    parameter int NUM_LEDS = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    blpc_event_if.sink           events,
    blpc_status_if.source        status,
    blpc_cfg_if.sink             cfg
);

    localparam blpc_pkg::led_idx_t LAST_LED = 3'(NUM_LEDS - 1);

    // Configuration registers
    blpc_pkg::debounce_t debounce_reg;
    blpc_pkg::limit_t    short_limit_reg;
    blpc_pkg::limit_t    long_limit_reg;
    blpc_pkg::limit_t    hp_slow_reg;
    blpc_pkg::limit_t    hp_mid_reg;
    blpc_pkg::limit_t    hp_fast_reg;

    // Input register
    logic in_valid_reg;
    logic in_mode_reg;
    logic in_level_reg;

    // Controller state
    blpc_pkg::ms_t      clock_reg,       clock_next;
    blpc_pkg::ms_t      last_edge_reg,   last_edge_next;
    blpc_pkg::ms_t      press_start_reg, press_start_next;
    logic               led_valid_reg,   led_valid_next;
    blpc_pkg::led_idx_t led_index_reg,   led_index_next;
    logic               led_lit_reg,     led_lit_next;
    logic               blink_reg,       blink_next;
    blpc_pkg::rate_t    rate_reg,        rate_next;
    blpc_pkg::ms_t      toggle_reg,      toggle_next;

    // Result register
    logic                out_valid_reg, out_valid_next;
    blpc_pkg::leds_t     out_leds_reg,  out_leds_next;
    logic                out_blink_reg;
    blpc_pkg::rate_t     out_rate_reg;
    blpc_pkg::action_t   out_action_reg, out_action_next;

    logic                  advance;
    logic                  edge_ok;
    blpc_pkg::press_info_t press_info;
    blpc_pkg::action_t     release_action;
    blpc_pkg::limit_t      half_period;
    logic [7:0]            led_onehot;

    // Item moves into the result register when the result slot is free
    assign advance      = in_valid_reg && (!out_valid_reg || status.ready);
    assign events.ready = !in_valid_reg || advance;
    assign cfg.ready    = 1'b1;

    assign status.valid       = out_valid_reg;
    assign status.lit_leds    = out_leds_reg;
    assign status.blink_on    = out_blink_reg;
    assign status.rate_select = out_rate_reg;
    assign status.action      = out_action_reg;

    // Ticks advance the clock before anything else looks at it
    assign clock_next = in_mode_reg ? clock_reg : clock_reg + 32'd1;
    assign edge_ok    = in_mode_reg &&
                        ((clock_next - last_edge_reg) >= {22'd0, debounce_reg});

    assign press_info.hold_ms       = clock_next - press_start_reg;
    assign press_info.short_limit   = short_limit_reg;
    assign press_info.long_limit    = long_limit_reg;
    assign press_info.blink_enabled = blink_reg;

    blpc_press_class u_press_class (
        .info   (press_info),
        .action (release_action)
    );

    always_comb
    begin
        last_edge_next   = last_edge_reg;
        press_start_next = press_start_reg;
        led_valid_next   = led_valid_reg;
        led_index_next   = led_index_reg;
        led_lit_next     = led_lit_reg;
        blink_next       = blink_reg;
        rate_next        = rate_reg;
        toggle_next      = toggle_reg;
        out_action_next  = blpc_pkg::ACT_NONE;
        half_period      = hp_fast_reg;

        if (edge_ok)
        begin
            last_edge_next = clock_next;
            if (in_level_reg)
            begin
                press_start_next = clock_next;
            end
            else
            begin
                out_action_next = release_action;
                toggle_next     = clock_next;
                case (release_action)
                    blpc_pkg::ACT_SHORT:
                    begin
                        // Step to the next LED, or the first one if none yet
                        if (!led_valid_reg || led_index_reg >= LAST_LED)
                        begin
                            led_index_next = '0;
                        end
                        else
                        begin
                            led_index_next = led_index_reg + 3'd1;
                        end
                        led_valid_next = 1'b1;
                        led_lit_next   = 1'b1;
                    end
                    blpc_pkg::ACT_MEDIUM:
                    begin
                        rate_next = (rate_reg >= blpc_pkg::RATE_FAST) ?
                                    blpc_pkg::RATE_SLOW : rate_reg + 2'd1;
                    end
                    default:
                    begin
                        blink_next = !blink_reg;
                    end
                endcase
            end
        end

        unique case (rate_next)
            blpc_pkg::RATE_SLOW: half_period = hp_slow_reg;
            blpc_pkg::RATE_MID:  half_period = hp_mid_reg;
            default:             half_period = hp_fast_reg;
        endcase

        // Blink check runs on every item, after the edge handling
        if (blink_next && led_valid_next &&
            ((clock_next - toggle_next) >= {16'd0, half_period}))
        begin
            toggle_next  = clock_next;
            led_lit_next = !led_lit_next;
        end
    end

    // Bits for LEDs beyond the output width fall off
    assign led_onehot    = 8'd1 << led_index_next;
    assign out_leds_next = (led_valid_next && led_lit_next) ?
                           led_onehot[blpc_pkg::LED_W-1:0] : '0;

    assign out_valid_next = advance || (out_valid_reg && !status.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg    <= blpc_pkg::DEBOUNCE_RST;
            short_limit_reg <= blpc_pkg::SHORT_RST;
            long_limit_reg  <= blpc_pkg::LONG_RST;
            hp_slow_reg     <= blpc_pkg::HP_SLOW_RST;
            hp_mid_reg      <= blpc_pkg::HP_MID_RST;
            hp_fast_reg     <= blpc_pkg::HP_FAST_RST;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            clock_reg       <= '0;
            last_edge_reg   <= '0;
            press_start_reg <= '0;
            led_valid_reg   <= 1'b0;
            led_index_reg   <= '0;
            led_lit_reg     <= 1'b0;
            blink_reg       <= 1'b1;
            rate_reg        <= blpc_pkg::RATE_SLOW;
            toggle_reg      <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    blpc_pkg::CFG_DEBOUNCE: debounce_reg    <= cfg.data[blpc_pkg::DEBOUNCE_W-1:0];
                    blpc_pkg::CFG_SHORT:    short_limit_reg <= cfg.data;
                    blpc_pkg::CFG_LONG:     long_limit_reg  <= cfg.data;
                    blpc_pkg::CFG_HP_SLOW:  hp_slow_reg     <= cfg.data;
                    blpc_pkg::CFG_HP_MID:   hp_mid_reg      <= cfg.data;
                    blpc_pkg::CFG_HP_FAST:  hp_fast_reg     <= cfg.data;
                    default: ;
                endcase
            end

            if (events.ready)
            begin
                in_valid_reg <= events.valid;
            end
            out_valid_reg <= out_valid_next;

            if (advance)
            begin
                clock_reg       <= clock_next;
                last_edge_reg   <= last_edge_next;
                press_start_reg <= press_start_next;
                led_valid_reg   <= led_valid_next;
                led_index_reg   <= led_index_next;
                led_lit_reg     <= led_lit_next;
                blink_reg       <= blink_next;
                rate_reg        <= rate_next;
                toggle_reg      <= toggle_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (events.valid && events.ready)
        begin
            in_mode_reg  <= events.mode;
            in_level_reg <= events.pin_level;
        end
        if (advance)
        begin
            out_leds_reg   <= out_leds_next;
            out_blink_reg  <= blink_next;
            out_rate_reg   <= rate_next;
            out_action_reg <= out_action_next;
        end
    end

endmodule

@@ design/blpc_checker.sv @@
// Checker: port-level assertions on the controller, bound to the top level.
`timescale 1ns / 1ps

module blpc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                ev_valid,
    input logic                ev_ready,
    input logic                st_valid,
    input logic                st_ready,
    input blpc_pkg::leds_t     lit_leds,
    input blpc_pkg::rate_t     rate_select,
    input blpc_pkg::action_t   action
);

    // Stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        st_valid && !st_ready |=>
            st_valid && $stable(lit_leds) && $stable(action))
        else $error("status payload changed while stalled");

    // At most one LED lit
    assert property (@(posedge clk) disable iff (!rst_n)
        st_valid |-> $onehot0(lit_leds))
        else $error("more than one LED lit");

    // Rate index stays within the three rates
    assert property (@(posedge clk) disable iff (!rst_n)
        st_valid |-> rate_select <= blpc_pkg::RATE_FAST)
        else $error("rate index out of range");

    // A fresh result follows an accepted item through the input and result registers
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(st_valid) |-> $past(ev_valid && ev_ready, 2))
        else $error("result without an accepted item");

endmodule

bind button_press_led_blink_controller_unit blpc_checker u_blpc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .ev_valid    (events.valid),
    .ev_ready    (events.ready),
    .st_valid    (status.valid),
    .st_ready    (status.ready),
    .lit_leds    (status.lit_leds),
    .rate_select (status.rate_select),
    .action      (status.action)
);

@@ sim/button_press_led_blink_controller_unit_test.sv @@
// Testbench for the button press classifier and LED blinker, self-checking against its own model.
`timescale 1ns / 1ps

module button_press_led_blink_controller_unit_test;

    localparam int NUM_LEDS     = 7;
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int SQUEEZE_LEN  = 48;     // long result stall, fills the two-deep pipe
    localparam int DRAIN_CYCLES = 4;      // wait after the last status item is checked

    // Event kinds and pin levels, as carried on the event channel
    typedef enum logic {EV_TICK = 1'b0, EV_EDGE = 1'b1} ev_mode_t;
    localparam logic PIN_UP   = 1'b1;     // pressed
    localparam logic PIN_DOWN = 1'b0;     // released

    // One status item as the block reports it
    typedef struct packed {
        blpc_pkg::leds_t   leds;
        logic              blink;
        blpc_pkg::rate_t   rate;
        blpc_pkg::action_t act;
    } led_status_t;

    // Directed plan: either an event or a register write
    typedef enum logic {ROW_EVENT = 1'b0, ROW_REG = 1'b1} row_kind_t;
    typedef struct {
        row_kind_t           kind;
        ev_mode_t            mode;
        logic                lvl;
        blpc_pkg::cfg_idx_t  idx;
        blpc_pkg::cfg_data_t data;
        logic                typed;     // expected status written out below
        led_status_t         want;
    } plan_row_t;

    localparam int PLAN_ROWS = 35;
    localparam led_status_t NO_WANT = '0;

    plan_row_t plan [PLAN_ROWS] = '{
        // reset settings: first tick, then a press inside the 50 ms debounce window
        '{ROW_EVENT, EV_TICK, PIN_DOWN, blpc_pkg::CFG_DEBOUNCE, 16'd0, 1'b1,
          '{7'h00, 1'b1, blpc_pkg::RATE_SLOW, blpc_pkg::ACT_NONE}},
        '{ROW_EVENT, EV_EDGE, PIN_UP,   blpc_pkg::CFG_DEBOUNCE, 16'd0, 1'b1,
          '{7'h00, 1'b1, blpc_pkg::RATE_SLOW, blpc_pkg::ACT_NONE}},
        // tiny limits: hold 0 short, 1 medium, 2+ long; fast rate toggles every item
        '{ROW_REG,   EV_TICK, PIN_DOWN, blpc_pkg::CFG_DEBOUNCE, 16'd0, 1'b0, NO_WANT},
        '{ROW_REG,   EV_TICK, PIN_DOWN, blpc_pkg::CFG_SHORT,    16'd1, 1'b0, NO_WANT},
        '{ROW_REG,   EV_TICK, PIN_DOWN, blpc_pkg::CFG_LONG,     16'd2, 1'b0, NO_WANT},
        '{ROW_REG,   EV_TICK, PIN_DOWN, blpc_pkg::CFG_HP_SLOW,  16'd3, 1'b0, NO_WANT},
        '{ROW_REG,   EV_TICK, PIN_DOWN, blpc_pkg::CFG_HP_MID,   16'd1, 1'b0, NO_WANT},
        '{ROW_REG,   EV_TICK, PIN_DOWN, blpc_pkg::CFG_HP_FAST,  16'd0, 1'b0, NO_WANT},
        // release with no press before it: measured from the reset press start
        '{ROW_EVENT, EV_EDGE, PIN_DOWN, blpc_pkg::CFG_DEBOUNCE, 16'd0, 1'b0, NO_WANT},
        // short press selects the first LED
        '{ROW_EVENT, EV_EDGE, PIN_UP,   blpc_pkg::CFG_DEBOUNCE, 16'd0, 1'b0, NO_WANT},
        '{ROW_EVENT, EV_EDGE, PIN_DOWN, blpc_pkg::CFG_DEBOUNCE, 16'd0, 1'b0, NO_WANT},
        '{ROW_EVENT, EV_TICK, PIN_DOWN, blpc_pkg::CFG_DEBOUNCE, 16'd0, 1'b0, NO_WANT},
        '{ROW_EVENT, EV_TICK, PIN_DOWN, blpc_pkg::CFG_DEBOUNCE, 16'd0, 1'b0, NO_WANT},
        // press twice while held, then a medium hold steps to the fast rate
        '{ROW_EVENT, EV_EDGE, PIN_UP,   blpc_pkg::CFG_DEBOUNCE, 16'd0, 1'b0, NO_WANT},
        '{ROW_EVENT, EV_EDGE, PIN_UP,   blpc_pkg::CFG_DEBOUNCE, 16'd0, 1'b0, NO_WANT},
        '{ROW_EVENT, EV_TICK, PIN_DOWN, blpc_pkg::CFG_DEBOUNCE, 16'd0, 1'b0, NO_WANT},
        '{ROW_EVENT, EV_EDGE, PIN_DOWN, blpc_pkg::CFG_DEBOUNCE, 16'd0, 1'b0, NO_WANT},
        '{ROW_EVENT, EV_TICK, PIN_DOWN, blpc_pkg::CFG_DEBOUNCE, 16'd0, 1'b0, NO_WANT},
        // long hold turns blinking off; the LED then keeps its level
        '{ROW_EVENT, EV_EDGE, PIN_UP,   blpc_pkg::CFG_DEBOUNCE, 16'd0, 1'b0, NO_WANT},
        '{ROW_EVENT, EV_TICK, PIN_DOWN, blpc_pkg::CFG_DEBOUNCE, 16'd0, 1'b0, NO_WANT},
        '{ROW_EVENT, EV_TICK, PIN_DOWN, blpc_pkg::CFG_DEBOUNCE, 16'd0, 1'b0, NO_WANT},
        '{ROW_EVENT, EV_EDGE, PIN_DOWN, blpc_pkg::CFG_DEBOUNCE, 16'd0, 1'b0, NO_WANT},
        '{ROW_EVENT, EV_TICK, PIN_DOWN, blpc_pkg::CFG_DEBOUNCE, 16'd0, 1'b0, NO_WANT},
        // medium hold with blinking off reports long and turns it back on
        '{ROW_EVENT, EV_EDGE, PIN_UP,   blpc_pkg::CFG_DEBOUNCE, 16'd0, 1'b0, NO_WANT},
        '{ROW_EVENT, EV_TICK, PIN_DOWN, blpc_pkg::CFG_DEBOUNCE, 16'd0, 1'b0, NO_WANT},
        '{ROW_EVENT, EV_EDGE, PIN_DOWN, blpc_pkg::CFG_DEBOUNCE, 16'd0, 1'b0, NO_WANT},
        // top of the limit and half-period ranges, debounce 1000: edges right after the last one are rejected
        '{ROW_REG,   EV_TICK, PIN_DOWN, blpc_pkg::CFG_DEBOUNCE, 16'd1000,  1'b0, NO_WANT},
        '{ROW_REG,   EV_TICK, PIN_DOWN, blpc_pkg::CFG_SHORT,    16'd65535, 1'b0, NO_WANT},
        '{ROW_REG,   EV_TICK, PIN_DOWN, blpc_pkg::CFG_LONG,     16'd65535, 1'b0, NO_WANT},
        '{ROW_REG,   EV_TICK, PIN_DOWN, blpc_pkg::CFG_HP_SLOW,  16'd65535, 1'b0, NO_WANT},
        '{ROW_REG,   EV_TICK, PIN_DOWN, blpc_pkg::CFG_HP_MID,   16'd65535, 1'b0, NO_WANT},
        '{ROW_REG,   EV_TICK, PIN_DOWN, blpc_pkg::CFG_HP_FAST,  16'd65535, 1'b0, NO_WANT},
        '{ROW_EVENT, EV_EDGE, PIN_UP,   blpc_pkg::CFG_DEBOUNCE, 16'd0, 1'b0, NO_WANT},
        '{ROW_EVENT, EV_TICK, PIN_UP,   blpc_pkg::CFG_DEBOUNCE, 16'd0, 1'b0, NO_WANT},
        '{ROW_EVENT, EV_EDGE, PIN_DOWN, blpc_pkg::CFG_DEBOUNCE, 16'd0, 1'b0, NO_WANT}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    blpc_event_if  ev();
    blpc_status_if st();
    blpc_cfg_if    cfg();

    button_press_led_blink_controller_unit #(
        .NUM_LEDS(NUM_LEDS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .events (ev),
        .status (st),
        .cfg    (cfg)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Controller model: register copies and state
    // ---------------------------------------------------------------
    blpc_pkg::debounce_t debounce_ms;
    blpc_pkg::limit_t    short_ms, long_ms;
    blpc_pkg::limit_t    half_slow, half_mid, half_fast;

    blpc_pkg::ms_t   ms_now, edge_at, press_at, toggle_at;
    logic            holding, led_sel_valid, led_on, blinking;
    int              led_pos;
    blpc_pkg::rate_t rate_sel;

    led_status_t pending_status [$];
    int          events_taken = 0;
    int          mismatches   = 0;

    // Idle control shared between the two sides
    logic calm        = 1'b0;   // no idling in the closing phase
    logic squeeze_now = 1'b0;   // ask the result side for one long stall
    logic squeezing   = 1'b0;   // that stall is in progress

    task automatic model_reset();
        debounce_ms   = blpc_pkg::DEBOUNCE_RST;
        short_ms      = blpc_pkg::SHORT_RST;
        long_ms       = blpc_pkg::LONG_RST;
        half_slow     = blpc_pkg::HP_SLOW_RST;
        half_mid      = blpc_pkg::HP_MID_RST;
        half_fast     = blpc_pkg::HP_FAST_RST;
        ms_now        = '0;
        edge_at       = '0;
        press_at      = '0;
        toggle_at     = '0;
        holding       = 1'b0;
        led_sel_valid = 1'b0;
        led_on        = 1'b0;
        blinking      = 1'b1;
        led_pos       = 0;
        rate_sel      = blpc_pkg::RATE_SLOW;
    endtask

    // Status after one event: tick advances time, an edge is debounced and
    // handled at the current time, then the blink timer is checked.
    function automatic led_status_t next_led_status(input logic m, input logic lvl);
        led_status_t      r;
        blpc_pkg::ms_t    hold;
        blpc_pkg::limit_t half;
        r.act = blpc_pkg::ACT_NONE;
        if (m == EV_TICK)
        begin
            ms_now = ms_now + 1;
        end
        else if (ms_now - edge_at >= blpc_pkg::ms_t'(debounce_ms))
        begin
            edge_at = ms_now;
            if (lvl == PIN_UP)
            begin
                holding  = 1'b1;
                press_at = ms_now;
            end
            else
            begin
                // release classifies from the last press start, held or not
                hold    = ms_now - press_at;
                holding = 1'b0;
                if (hold < blpc_pkg::ms_t'(short_ms))
                begin
                    led_pos       = led_sel_valid ? (led_pos + 1) % NUM_LEDS : 0;
                    led_sel_valid = 1'b1;
                    led_on        = 1'b1;
                    toggle_at     = ms_now;
                    r.act         = blpc_pkg::ACT_SHORT;
                end
                else if (hold < blpc_pkg::ms_t'(long_ms) && blinking)
                begin
                    rate_sel  = (rate_sel == blpc_pkg::RATE_FAST) ? blpc_pkg::RATE_SLOW :
                                blpc_pkg::rate_t'(rate_sel + 1);
                    toggle_at = ms_now;
                    r.act     = blpc_pkg::ACT_MEDIUM;
                end
                else
                begin
                    blinking  = !blinking;
                    toggle_at = ms_now;
                    r.act     = blpc_pkg::ACT_LONG;
                end
            end
        end
        case (rate_sel)
            blpc_pkg::RATE_SLOW: half = half_slow;
            blpc_pkg::RATE_MID:  half = half_mid;
            default:             half = half_fast;
        endcase
        if (blinking && led_sel_valid && ms_now - toggle_at >= blpc_pkg::ms_t'(half))
        begin
            toggle_at = ms_now;
            led_on    = !led_on;
        end
        r.leds  = (led_sel_valid && led_on) ? blpc_pkg::leds_t'(1 << led_pos) : '0;
        r.blink = blinking;
        r.rate  = rate_sel;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Event side
    // ---------------------------------------------------------------
    task automatic drive_event(input logic m, input logic lvl, input logic typed,
                               input led_status_t want);
        led_status_t got;
        cfg.valid <= 1'b0;
        if (!calm && !squeezing && $urandom_range(0, 7) == 0)
        begin
            ev.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        ev.valid     <= 1'b1;
        ev.mode      <= m;
        ev.pin_level <= lvl;
        do @(posedge clk); while (!ev.ready);
        events_taken++;
        got = next_led_status(m, lvl);
        if (typed)
            got = want;
        pending_status.push_back(got);
    endtask

    // Register write, only once the block has nothing in flight
    task automatic write_reg(input blpc_pkg::cfg_idx_t idx, input int value);
        ev.valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= blpc_pkg::cfg_data_t'(value);
        do @(posedge clk); while (!cfg.ready);
        case (idx)
            blpc_pkg::CFG_DEBOUNCE: debounce_ms = blpc_pkg::debounce_t'(value);
            blpc_pkg::CFG_SHORT:    short_ms    = blpc_pkg::limit_t'(value);
            blpc_pkg::CFG_LONG:     long_ms     = blpc_pkg::limit_t'(value);
            blpc_pkg::CFG_HP_SLOW:  half_slow   = blpc_pkg::limit_t'(value);
            blpc_pkg::CFG_HP_MID:   half_mid    = blpc_pkg::limit_t'(value);
            blpc_pkg::CFG_HP_FAST:  half_fast   = blpc_pkg::limit_t'(value);
            default: ;
        endcase
    endtask

    task automatic set_regs(input int deb, input int sh, input int lg,
                            input int hs, input int hm, input int hf);
        write_reg(blpc_pkg::CFG_DEBOUNCE, deb);
        write_reg(blpc_pkg::CFG_SHORT, sh);
        write_reg(blpc_pkg::CFG_LONG, lg);
        write_reg(blpc_pkg::CFG_HP_SLOW, hs);
        write_reg(blpc_pkg::CFG_HP_MID, hm);
        write_reg(blpc_pkg::CFG_HP_FAST, hf);
    endtask

    // Mostly whole presses (wait out debounce, press, hold, release) with
    // random hold length around the limits; the rest is random noise.
    task automatic run_phase(input int budget);
        int start, gap, hold, span;
        start = events_taken;
        while (events_taken - start < budget)
        begin
            if (debounce_ms <= 64 && $urandom_range(0, 9) < 7)
            begin
                gap = debounce_ms + $urandom_range(0, 3);
                if (gap > 0 && $urandom_range(0, 15) == 0)
                    gap--;                              // press may land in the window
                repeat (gap)
                    drive_event(EV_TICK, 1'($urandom_range(0, 1)), 1'b0, NO_WANT);
                drive_event(EV_EDGE, PIN_UP, 1'b0, NO_WANT);
                if ($urandom_range(0, 7) == 0)
                    drive_event(EV_EDGE, PIN_UP, 1'b0, NO_WANT);   // contact bounce
                span = ((short_ms > long_ms) ? int'(short_ms) : int'(long_ms)) + 2;
                if (span > 24)
                    span = 24;
                hold = debounce_ms + $urandom_range(0, span);
                repeat (hold)
                    drive_event(EV_TICK, 1'($urandom_range(0, 1)), 1'b0, NO_WANT);
                drive_event(EV_EDGE, PIN_DOWN, 1'b0, NO_WANT);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    drive_event(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                1'b0, NO_WANT);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Result side: random stall bursts plus one long squeeze on request
    // ---------------------------------------------------------------
    initial
    begin : result_sink
        int stall_left;
        logic squeeze_done;
        stall_left   = 0;
        squeeze_done = 1'b0;
        st.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (squeeze_now && !squeeze_done && stall_left == 0)
            begin
                stall_left   = SQUEEZE_LEN;
                squeeze_done = 1'b1;
                squeezing    = 1'b1;
            end
            else if (!calm && stall_left == 0 && $urandom_range(0, 11) == 0)
            begin
                stall_left = $urandom_range(1, 18);
            end
            if (stall_left > 0)
            begin
                st.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                st.ready  <= 1'b1;
                squeezing  = 1'b0;
            end
        end
    end

    // Compare each accepted status item with the oldest expectation
    always @(posedge clk)
    begin : status_check
        led_status_t want;
        if (rst_n && st.valid && st.ready)
        begin
            if (pending_status.size() == 0)
            begin
                $display("%0t: status item with none expected: leds %h blink %0d rate %0d act %0d",
                         $time, st.lit_leds, st.blink_on, st.rate_select, st.action);
                mismatches++;
            end
            else
            begin
                want = pending_status.pop_front();
                if (st.lit_leds !== want.leds)
                begin
                    $display("%0t: lit_leds expected %h got %h", $time, want.leds, st.lit_leds);
                    mismatches++;
                end
                if (st.blink_on !== want.blink)
                begin
                    $display("%0t: blink_on expected %0d got %0d", $time, want.blink, st.blink_on);
                    mismatches++;
                end
                if (st.rate_select !== want.rate)
                begin
                    $display("%0t: rate_select expected %0d got %0d",
                             $time, want.rate, st.rate_select);
                    mismatches++;
                end
                if (st.action !== want.act)
                begin
                    $display("%0t: action expected %0d got %0d", $time, want.act, st.action);
                    mismatches++;
                end
            end
        end
    end

    // Hard stop if the run hangs
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin : stimulus
        int r, ph;
        model_reset();
        ev.valid     <= 1'b0;
        ev.mode      <= EV_TICK;
        ev.pin_level <= PIN_DOWN;
        cfg.valid    <= 1'b0;
        cfg.index    <= blpc_pkg::CFG_DEBOUNCE;
        cfg.data     <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < PLAN_ROWS; r++)
        begin
            if (plan[r].kind == ROW_REG)
                write_reg(plan[r].idx, int'(plan[r].data));
            else
                drive_event(plan[r].mode, plan[r].lvl, plan[r].typed, plan[r].want);
        end

        // Random phases; the squeeze lands in phase 1, the last phase runs flat out
        for (ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: set_regs(0, 1, 1, 0, 0, 0);                      // bottom of debounce and half-period ranges
                1: set_regs(3, 5, 10, 2, 3, 1);
                2: set_regs(1000, 65535, 65535, 65535, 65535, 65535); // top of limit ranges
                3: set_regs(4, 8, 3, 5, 2, 7);                      // long below short
                default: set_regs($urandom_range(0, 6), $urandom_range(1, 12),
                                  $urandom_range(1, 20), $urandom_range(0, 9),
                                  $urandom_range(0, 9), $urandom_range(0, 9));
            endcase
            squeeze_now = (ph == 1);
            calm        = (ph == 6);
            run_phase((ph == 2) ? 60 : 130);
        end

        ev.valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ button_press_led_blink_controller_unit.f @@
design/blpc_pkg.sv
design/blpc_if.sv
design/blpc_press_class.sv
design/button_press_led_blink_controller_unit.sv
design/blpc_checker.sv
sim/button_press_led_blink_controller_unit_test.sv
